// ----- sv/smf_pkg.sv -----
// shared helpers for the sliding median filter
// no dependencies; imported by smf_front, smf_back and sliding_median_filter_top
package smf_pkg;

  // flat position of the (row, col) compare bit in a width x width matrix
  function automatic int pair_idx(input int row, input int col, input int width);
    return row * width + col;
  endfunction

endpackage

// ----- sv/smf_front.sv -----
// front part: takes samples, shifts the window and builds the pairwise compare matrix
// depends on smf_pkg
module smf_front import smf_pkg::*; #(
  parameter int WINDOW      = 9,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [WINDOW*SAMPLE_BITS-1:0] push_window_o,
  output logic [WINDOW*WINDOW-1:0]      push_le_o
);

  logic [SAMPLE_BITS-1:0] window_q [WINDOW];
  logic [SAMPLE_BITS-1:0] window_d [WINDOW];
  logic                   accept;

  assign accept       = valid_i & push_ready_i;
  assign ready_o      = push_ready_i;
  assign push_valid_o = valid_i;

  always_comb begin
    window_d[0] = sample_i;
    for (int i = 1; i < WINDOW; i++) begin
      window_d[i] = window_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        window_q[i] <= '0;
      end
    end else if (accept) begin
      window_q <= window_d;
    end
  end

  // le bit (r, c) for r < c: entry r ranks before entry c
  for (genvar r = 0; r < WINDOW; r++) begin : g_row
    assign push_window_o[r*SAMPLE_BITS +: SAMPLE_BITS] = window_d[r];
    for (genvar c = 0; c < WINDOW; c++) begin : g_col
      localparam int Idx = pair_idx(r, c, WINDOW);
      if (r < c) begin : g_cmp
        assign push_le_o[Idx] = $signed(window_d[r]) <= $signed(window_d[c]);
      end else begin : g_zero
        assign push_le_o[Idx] = 1'b0;
      end
    end
  end

  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> window_q[0] == $past(sample_i))
    else $error("window head does not hold the accepted sample");

endmodule

// ----- sv/smf_queue.sv -----
// two-entry queue between the front and back parts
// no dependencies
module smf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = count_q != CNT_W'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = data_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_W'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill count");

endmodule

// ----- sv/smf_back.sv -----
// back part: ranks window entries from the compare matrix and registers the median
// depends on smf_pkg
module smf_back import smf_pkg::*; #(
  parameter int WINDOW      = 9,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [WINDOW*SAMPLE_BITS-1:0] pop_window_i,
  input  logic [WINDOW*WINDOW-1:0]      pop_le_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [SAMPLE_BITS-1:0]        median_o
);

  localparam int RANK_W = $clog2(WINDOW);
  localparam logic [RANK_W-1:0] MedRank = RANK_W'(WINDOW >> 1);

  logic [RANK_W-1:0]      rank [WINDOW];
  logic [WINDOW-1:0]      sel;
  logic [SAMPLE_BITS-1:0] median_d, median_q;
  logic                   valid_q, valid_d;
  logic                   load;

  assign pop_ready_o = !valid_q | ready_i;
  assign load        = pop_valid_i & pop_ready_o;
  assign valid_o     = valid_q;
  assign median_o    = median_q;

  // stable rank of each entry
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j < i) begin
          rank[i] = rank[i] + RANK_W'(pop_le_i[pair_idx(j, i, WINDOW)]);
        end else if (j > i) begin
          rank[i] = rank[i] + RANK_W'(!pop_le_i[pair_idx(i, j, WINDOW)]);
        end
      end
      sel[i] = rank[i] == MedRank;
    end
  end

  always_comb begin
    median_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      median_d = median_d
               | ({SAMPLE_BITS{sel[i]}} & pop_window_i[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      median_q <= median_d;
    end
  end

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> $onehot(sel))
    else $error("median select is not one-hot");

endmodule

// ----- sv/sliding_median_filter_top.sv -----
// sliding median filter: top level tying front, queue and back together
// depends on smf_pkg, smf_front, smf_queue, smf_back
//
// usage:
//   s_axis carries one signed sample per request in the low SAMPLE_BITS of
//   tdata; padding bits up to the byte boundary are ignored. each accepted
//   sample is shifted into a window of the last WINDOW samples and m_axis
//   returns the median of that window (rank WINDOW>>1, ascending), one result
//   per request, zero-padded to whole bytes.
//   an accepted sample's window and compare bits are registered in the queue;
//   the back then ranks them and registers the median in the output register.
//   throughput: one sample per cycle while s_axis_tready is high; the front
//   compares all window pairs in the accept cycle, the back ranks when it pops.
//   reset clears the window to zeros, so early medians include those zeros,
//   and empties the two-entry queue and the output register.
//   when m_axis stalls the output register holds its result, the queue takes
//   up to two more samples, then s_axis_tready drops until space frees up.
module sliding_median_filter_top import smf_pkg::*; #(
  parameter int WINDOW      = 9,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,   // sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata    // median_value
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int WIN_W   = WINDOW * SAMPLE_BITS;
  localparam int LE_W    = WINDOW * WINDOW;
  localparam int Q_W     = WIN_W + LE_W;

  logic                   push_valid, push_ready;
  logic [WIN_W-1:0]       push_window;
  logic [LE_W-1:0]        push_le;
  logic                   pop_valid, pop_ready;
  logic [Q_W-1:0]         pop_data;
  logic [SAMPLE_BITS-1:0] median;

  smf_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_window_o (push_window),
    .push_le_o     (push_le)
  );

  smf_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_data_i   ({push_le, push_window}),
    .out_valid_o (pop_valid),
    .out_ready_i (pop_ready),
    .out_data_o  (pop_data)
  );

  smf_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_window_i (pop_data[WIN_W-1:0]),
    .pop_le_i     (pop_data[Q_W-1:WIN_W]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .median_o     (median)
  );

  assign m_axis_tdata = TDATA_W'(median);

endmodule
